// File: src/ilha_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ilha_pkg
// Shared types and codes for the implicit-list heap allocator.
// ---------------------------------------------------------------------------
package ilha_pkg;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_FIT    = 3'd1;
	localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
	localparam logic [2:0] ST_BAD_ADDR  = 3'd3;
	localparam logic [2:0] ST_NOT_ALLOC = 3'd4;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture request, reset walk
		logic rd;        // read tag at the selected address
		logic step;      // evaluate read tag
		logic wr;        // perform one write of the selected op
		logic [3:0] sel;
	} ilha_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic walk_done;
		logic hit;       // allocate: found; free: header matches allocated block
		logic split;     // allocate: remainder large enough to split off
		logic merge_prev;
		logic merge_next;
		logic zero_done;
	} ilha_sts_t;

	localparam logic [3:0] W_A_HEAD  = 4'd0;
	localparam logic [3:0] W_A_FOOT  = 4'd1;
	localparam logic [3:0] W_A_RHEAD = 4'd2;
	localparam logic [3:0] W_A_RFOOT = 4'd3;
	localparam logic [3:0] W_F_ZERO  = 4'd4;
	localparam logic [3:0] W_F_HEAD  = 4'd5;
	localparam logic [3:0] W_F_FOOT  = 4'd6;
	localparam logic [3:0] W_F_PZ0   = 4'd7;
	localparam logic [3:0] W_F_PZ1   = 4'd8;
	localparam logic [3:0] W_F_NZ0   = 4'd9;
	localparam logic [3:0] W_F_NZ1   = 4'd10;
	localparam logic [3:0] R_WALK    = 4'd11;
	localparam logic [3:0] R_PREV    = 4'd12;
	localparam logic [3:0] R_NEXT    = 4'd13;

endpackage
`default_nettype wire

// File: src/implicit_list_heap_allocator_top.sv
`default_nettype none
// Allocate walks the block tags, writes header and footer, and the remainder's when
// one is split off; free walks the tags to the header, zeroes the payload, writes
// header and footer, and clears the inner tags of each neighbor merged; a bad size
// or address goes straight to the result. One request in flight; the next transfer
// is taken in the cycle after the result transfer. After reset a fill pass writes
// the initial heap; no request is taken until it ends.
// ---------------------------------------------------------------------------
// implicit_list_heap_allocator_top
// Boundary-tag heap allocator, first or best fit, with free and merge.
// ---------------------------------------------------------------------------
module implicit_list_heap_allocator_top #(
	parameter int HEAP_BYTES = 127
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // request_size[7:0], free_address[15:8]
	input  wire logic        s_tuser,   // mode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata    // payload_address[6:0], status[9:7], zero pad
);
	localparam logic [7:0] MAXV = 8'(HEAP_BYTES - 2);
	logic fit_q, go, idle, rv, aok, init_busy;
	logic [2:0] rst;
	logic [6:0] pa;
	ilha_pkg::ilha_cmd_t cmd;
	ilha_pkg::ilha_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fit_q <= 1'b0;
		else if (cfg_we) fit_q <= cfg_wdata;
	end

	assign s_tready = idle;
	assign go = s_tvalid && idle;

	ilha_ctrl u_ctrl (
		.clk, .arst_n, .in_go(go), .mode(s_tuser),
		.size_ok(s_tdata[7:0] >= 8'd1 && s_tdata[7:0] <= MAXV),
		.addr_ok(s_tdata[15:8] >= 8'd1 && s_tdata[15:8] <= MAXV),
		.init_busy, .out_free(m_tready), .sts, .cmd, .idle,
		.res_vld(rv), .res_st(rst), .res_adr_ok(aok)
	);

	ilha_datapath #(.HEAP_BYTES(HEAP_BYTES)) u_dp (
		.clk, .arst_n, .cmd, .sts, .fit_policy(fit_q), .mode(s_tuser),
		.request_size(s_tdata[7:0]), .free_address(s_tdata[15:8]),
		.pick_addr(pa), .init_busy
	);

	assign m_tvalid = rv;
	assign m_tdata  = {6'd0, rst, aok ? pa : 7'd0};
endmodule
`default_nettype wire

// File: src/ilha_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ilha_datapath
// Heap memory, tag walk, fit selection, split and merge arithmetic.
// ---------------------------------------------------------------------------
module ilha_datapath #(
	parameter int HEAP_BYTES = 127
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire ilha_pkg::ilha_cmd_t cmd,
	output ilha_pkg::ilha_sts_t sts,
	input  wire logic fit_policy,
	input  wire logic mode,
	input  wire logic [7:0] request_size,
	input  wire logic [7:0] free_address,
	output logic [6:0] pick_addr,
	output logic init_busy
);
	localparam logic [7:0] HB = 8'(HEAP_BYTES);

	logic [7:0] mem [HEAP_BYTES];
	logic [7:0] rdata_q;
	logic [7:0] pos_q, req_q, pick_q, psize_q, head_q, size_q, foot_q, zi_q;
	logic [7:0] ohead_q, ofoot_q, init_q;
	logic       found_q, pol_q, done_q, mode_q, pm_q, nm_q;
	logic [6:0] ts;
	logic [7:0] s, need, diff, nsz, waddr, wdata, raddr, pos_nx, init_word;
	logic       good, fit, split, prev_ok, next_ok;

	assign init_busy = (init_q != HB);
	assign ts     = rdata_q[7:1];
	assign s      = {1'b0, ts};
	assign good   = (ts != 7'd0) && ({1'b0, pos_q} + {1'b0, s} <= {1'b0, HB});
	assign pos_nx = pos_q + s;
	assign need   = req_q + 8'd2;
	assign fit    = !rdata_q[0] && (s >= need);
	assign diff   = psize_q - need;
	assign split  = (diff >= 8'd3);
	assign nsz    = split ? need : psize_q;
	assign pick_addr = 7'(pick_q + 8'd1);
	assign prev_ok = (head_q != 8'd0) && !rdata_q[0] && (ts != 7'd0) && (s <= head_q);
	assign next_ok = (foot_q < HB - 8'd1) && !rdata_q[0] && (ts != 7'd0) &&
	                 ({1'b0, foot_q} + 9'd1 + {1'b0, s} <= {1'b0, HB});
	assign init_word = (init_q == 8'd0 || init_q == HB - 8'd1) ? {HB[6:0], 1'b0} : 8'd0;

	// read select
	always_comb begin
		case (cmd.sel)
			ilha_pkg::R_PREV: raddr = (head_q == 8'd0) ? 8'd0 : head_q - 8'd1;
			ilha_pkg::R_NEXT: raddr = (foot_q >= HB - 8'd1) ? foot_q : foot_q + 8'd1;
			default:          raddr = pos_q;
		endcase
	end

	// write select
	always_comb begin
		waddr = 8'd0;
		wdata = 8'd0;
		case (cmd.sel)
			ilha_pkg::W_A_HEAD:  begin waddr = pick_q; wdata = {nsz[6:0], 1'b1}; end
			ilha_pkg::W_A_FOOT:  begin
				waddr = pick_q + nsz - 8'd1;
				wdata = {nsz[6:0], 1'b1};
			end
			ilha_pkg::W_A_RHEAD: begin waddr = pick_q + need; wdata = {diff[6:0], 1'b0}; end
			ilha_pkg::W_A_RFOOT: begin
				waddr = pick_q + psize_q - 8'd1;
				wdata = {diff[6:0], 1'b0};
			end
			ilha_pkg::W_F_ZERO:  waddr = zi_q;
			ilha_pkg::W_F_HEAD:  begin waddr = head_q; wdata = {size_q[6:0], 1'b0}; end
			ilha_pkg::W_F_FOOT:  begin waddr = foot_q; wdata = {size_q[6:0], 1'b0}; end
			ilha_pkg::W_F_PZ0:   waddr = ohead_q - 8'd1;
			ilha_pkg::W_F_PZ1:   waddr = ohead_q;
			ilha_pkg::W_F_NZ0:   waddr = ofoot_q;
			ilha_pkg::W_F_NZ1:   waddr = ofoot_q + 8'd1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (init_busy)
			mem[init_q[6:0]] <= init_word;
		else if (cmd.wr)
			mem[waddr[6:0]] <= wdata;
		if (cmd.rd)
			rdata_q <= mem[raddr[6:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q  <= 8'd0;
			done_q  <= 1'b0;
			found_q <= 1'b0;
			mode_q  <= 1'b0;
			pol_q   <= 1'b0;
			pm_q    <= 1'b0;
			nm_q    <= 1'b0;
			req_q   <= 8'd0;
			pos_q   <= 8'd0;
			pick_q  <= 8'd0;
			psize_q <= 8'd0;
			head_q  <= 8'd0;
			size_q  <= 8'd0;
			foot_q  <= 8'd0;
			ohead_q <= 8'd0;
			ofoot_q <= 8'd0;
			zi_q    <= 8'd0;
		end else begin
			if (init_busy) init_q <= init_q + 8'd1;
			if (cmd.load) begin
				mode_q  <= mode;
				pol_q   <= fit_policy;
				req_q   <= request_size;
				head_q  <= free_address - 8'd1;
				pos_q   <= 8'd0;
				found_q <= 1'b0;
				done_q  <= 1'b0;
				pm_q    <= 1'b0;
				nm_q    <= 1'b0;
			end else if (cmd.step) begin
				case (cmd.sel)
					ilha_pkg::R_PREV: if (prev_ok) begin
						pm_q   <= 1'b1;
						head_q <= head_q - s;
						size_q <= size_q + s;
					end
					ilha_pkg::R_NEXT: if (next_ok) begin
						nm_q   <= 1'b1;
						foot_q <= foot_q + s;
						size_q <= size_q + s;
					end
					default: begin
						if (!mode_q) begin
							if (!good) done_q <= 1'b1;
							else begin
								if (fit && (!found_q || (pol_q && s < psize_q))) begin
									found_q <= 1'b1;
									pick_q  <= pos_q;
									psize_q <= s;
								end
								if (fit && !pol_q) done_q <= 1'b1;
								pos_q <= pos_nx;
								if (pos_nx > HB - 8'd3) done_q <= 1'b1;
							end
						end else begin
							// walk to header; hit when exact match and allocated
							if (pos_q >= head_q) begin
								done_q  <= 1'b1;
								found_q <= (pos_q == head_q) && good && rdata_q[0];
								size_q  <= s;
								foot_q  <= head_q + s - 8'd1;
								ohead_q <= head_q;
								ofoot_q <= head_q + s - 8'd1;
								zi_q    <= head_q + 8'd1;
							end else if (!good) begin
								done_q <= 1'b1;
							end else begin
								pos_q <= pos_nx;
								// jumped past the address: it is not a header
								if (pos_nx > head_q) done_q <= 1'b1;
							end
						end
					end
				endcase
			end
			if (cmd.wr && cmd.sel == ilha_pkg::W_F_ZERO) zi_q <= zi_q + 8'd1;
		end
	end

	always_comb begin
		sts.walk_done  = done_q;
		sts.hit        = found_q;
		sts.split      = split;
		sts.merge_prev = pm_q;
		sts.merge_next = nm_q;
		sts.zero_done  = (zi_q >= foot_q);
	end
endmodule
`default_nettype wire

// File: src/ilha_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ilha_ctrl
// Sequencer for allocate and free requests.
// ---------------------------------------------------------------------------
module ilha_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_go,
	input  wire logic mode,
	input  wire logic size_ok,
	input  wire logic addr_ok,
	input  wire logic init_busy,
	input  wire logic out_free,
	input  wire ilha_pkg::ilha_sts_t sts,
	output ilha_pkg::ilha_cmd_t cmd,
	output logic idle,
	output logic res_vld,
	output logic [2:0] res_st,
	output logic res_adr_ok
);
	localparam logic [4:0] S_IDLE = 5'd0, S_RD = 5'd1, S_STEP = 5'd2, S_CHK = 5'd3,
		S_AH = 5'd4, S_AF = 5'd5, S_ARH = 5'd6, S_ARF = 5'd7, S_ZERO = 5'd8,
		S_PRD = 5'd9, S_PEV = 5'd10, S_NRD = 5'd11, S_NEV = 5'd12, S_FH = 5'd13,
		S_FF = 5'd14, S_PZ0 = 5'd15, S_PZ1 = 5'd16, S_NZ0 = 5'd17, S_NZ1 = 5'd18,
		S_DONE = 5'd19;
	logic [4:0] st_q;
	logic       mode_q;
	logic [2:0] code_q;

	assign idle = (st_q == S_IDLE) && !init_busy;
	assign res_vld = (st_q == S_DONE);
	assign res_st = code_q;
	assign res_adr_ok = !mode_q && (code_q == ilha_pkg::ST_OK);

	always_comb begin
		cmd = '0;
		unique case (st_q)
			S_IDLE: cmd.load = in_go;
			S_RD:   begin cmd.rd = 1'b1; cmd.sel = ilha_pkg::R_WALK; end
			S_STEP: begin cmd.step = 1'b1; cmd.sel = ilha_pkg::R_WALK; end
			// next tag read overlaps the done check
			S_CHK:  begin cmd.rd = !sts.walk_done; cmd.sel = ilha_pkg::R_WALK; end
			S_AH:   begin cmd.wr = 1'b1; cmd.sel = ilha_pkg::W_A_HEAD; end
			S_AF:   begin cmd.wr = 1'b1; cmd.sel = ilha_pkg::W_A_FOOT; end
			S_ARH:  begin cmd.wr = 1'b1; cmd.sel = ilha_pkg::W_A_RHEAD; end
			S_ARF:  begin cmd.wr = 1'b1; cmd.sel = ilha_pkg::W_A_RFOOT; end
			S_ZERO: begin cmd.wr = !sts.zero_done; cmd.sel = ilha_pkg::W_F_ZERO; end
			S_PRD:  begin cmd.rd = 1'b1; cmd.sel = ilha_pkg::R_PREV; end
			S_PEV:  begin cmd.step = 1'b1; cmd.sel = ilha_pkg::R_PREV; end
			S_NRD:  begin cmd.rd = 1'b1; cmd.sel = ilha_pkg::R_NEXT; end
			S_NEV:  begin cmd.step = 1'b1; cmd.sel = ilha_pkg::R_NEXT; end
			S_FH:   begin cmd.wr = 1'b1; cmd.sel = ilha_pkg::W_F_HEAD; end
			S_FF:   begin cmd.wr = 1'b1; cmd.sel = ilha_pkg::W_F_FOOT; end
			S_PZ0:  begin cmd.wr = 1'b1; cmd.sel = ilha_pkg::W_F_PZ0; end
			S_PZ1:  begin cmd.wr = 1'b1; cmd.sel = ilha_pkg::W_F_PZ1; end
			S_NZ0:  begin cmd.wr = 1'b1; cmd.sel = ilha_pkg::W_F_NZ0; end
			S_NZ1:  begin cmd.wr = 1'b1; cmd.sel = ilha_pkg::W_F_NZ1; end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			mode_q <= 1'b0;
			code_q <= ilha_pkg::ST_OK;
		end else begin
			unique case (st_q)
				S_IDLE: if (in_go) begin
					mode_q <= mode;
					code_q <= ilha_pkg::ST_OK;
					if (!mode && !size_ok) begin
						code_q <= ilha_pkg::ST_BAD_SIZE;
						st_q <= S_DONE;
					end else if (mode && !addr_ok) begin
						code_q <= ilha_pkg::ST_BAD_ADDR;
						st_q <= S_DONE;
					end else st_q <= S_RD;
				end
				S_RD:   st_q <= S_STEP;
				S_STEP: st_q <= S_CHK;
				S_CHK:  if (!sts.walk_done) st_q <= S_STEP;
					else if (!sts.hit) begin
						code_q <= mode_q ? ilha_pkg::ST_NOT_ALLOC : ilha_pkg::ST_NO_FIT;
						st_q <= S_DONE;
					end else st_q <= mode_q ? S_ZERO : S_AH;
				S_AH:   st_q <= S_AF;
				S_AF:   st_q <= sts.split ? S_ARH : S_DONE;
				S_ARH:  st_q <= S_ARF;
				S_ARF:  st_q <= S_DONE;
				S_ZERO: if (sts.zero_done) st_q <= S_PRD;
				S_PRD:  st_q <= S_PEV;
				S_PEV:  st_q <= S_NRD;
				S_NRD:  st_q <= S_NEV;
				S_NEV:  st_q <= S_FH;
				S_FH:   st_q <= S_FF;
				S_FF:   st_q <= sts.merge_prev ? S_PZ0 : (sts.merge_next ? S_NZ0 : S_DONE);
				S_PZ0:  st_q <= S_PZ1;
				S_PZ1:  st_q <= sts.merge_next ? S_NZ0 : S_DONE;
				S_NZ0:  st_q <= S_NZ1;
				S_NZ1:  st_q <= S_DONE;
				S_DONE: if (out_free) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
